@@ rtl/bba_pkg.sv @@
`default_nettype none
package bba_pkg;

   localparam int ARENA_ORDER    = 20;
   localparam int GRAIN_ORDER    = 6;
   localparam int MIN_ALIGN_LOG2 = 4;
   localparam int GRAIN_BITS     = ARENA_ORDER - GRAIN_ORDER;
   localparam int NGRAINS        = 1 << GRAIN_BITS;
   localparam int NORDERS        = ARENA_ORDER - GRAIN_ORDER + 1;
   localparam int LINK_W         = GRAIN_BITS + 1;
   localparam int LIST_W         = $clog2(NORDERS);
   localparam int ORD_W          = 5;
   localparam int SIZE_W         = 21;
   localparam int OFF_W          = 20;
   localparam int CFG_W          = 8;
   localparam int CSR_IDX_W      = 2;
   localparam int NEED_W         = 33;
   localparam int FIFO_DEPTH     = 2;

   localparam logic [LINK_W-1:0] NIL = LINK_W'(NGRAINS);
   localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

   localparam logic [1:0] GS_NONE = 2'd0;
   localparam logic [1:0] GS_FREE = 2'd1;
   localparam logic [1:0] GS_USED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FOOTER = 2'd1;

   localparam logic [CFG_W-1:0] PREFIX_RESET = 8'd40;
   localparam logic [CFG_W-1:0] FOOTER_RESET = 8'd16;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OOM      = 2'd1,
      STATUS_BAD_FREE = 2'd2,
      STATUS_BAD_SIZE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      K_ALLOC  = 2'd0,
      K_FREE   = 2'd1,
      K_REJECT = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      status_type              fail_status;
      logic [ORD_W-1:0]        ord;
      logic [SIZE_W-1:0]       size;
      logic [ORD_W-1:0]        alog;
      logic [GRAIN_BITS-1:0]   grain;
      logic [CFG_W-1:0]        prefix;
   } item_type;

endpackage
`default_nettype wire

@@ rtl/bba_if.sv @@
`default_nettype none
interface bba_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [20:0] request_bytes;
   logic [4:0]  align_log2;
   logic [19:0] free_offset;
   modport source (output valid, opcode, request_bytes, align_log2, free_offset, input ready);
   modport sink   (input valid, opcode, request_bytes, align_log2, free_offset, output ready);
endinterface

interface bba_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [19:0] block_offset;
   logic [19:0] user_offset;
   logic [4:0]  block_order;
   logic [20:0] bytes_in_use;
   logic [20:0] peak_bytes;
   modport source (output valid, status, block_offset, user_offset, block_order,
                   bytes_in_use, peak_bytes, input ready);
   modport sink   (input valid, status, block_offset, user_offset, block_order,
                   bytes_in_use, peak_bytes, output ready);
endinterface

interface bba_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/buddy_block_allocator.sv @@
// Allocate: search the lists, pop a free block, split it once per order (up to 14 splits),
// then mark it used; front rejects and no-free-block results go straight to the response.
// Free: check the block, merge free buddies (up to 14), push it; a bad free stops at the check.
// One transaction at a time in the back end; a 2-entry queue lets the next
// request enter while the current one runs. The grain table memory port sets the pace.
// Reset: synchronous, active high; clearing all 16384 grains holds off requests, not CSRs.
`default_nettype none
module buddy_block_allocator
   import bba_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   bba_req_if.sink   req_chan,
   bba_rsp_if.source rsp_chan,
   bba_csr_if.sink   csr_chan
);

   logic     q_push, q_pop, q_full, q_empty, init_done;
   item_type push_item, pop_item;

   bba_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_chan  (csr_chan),
      .q_full    (q_full),
      .init_done (init_done),
      .q_push    (q_push),
      .q_item    (push_item)
   );

   bba_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .empty     (q_empty)
   );

   bba_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_item    (pop_item),
      .q_pop     (q_pop),
      .init_done (init_done),
      .rsp_chan  (rsp_chan)
   );

endmodule
`default_nettype wire

@@ rtl/bba_front.sv @@
`default_nettype none
module bba_front
   import bba_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   bba_req_if.sink    req_chan,
   bba_csr_if.sink    csr_chan,
   input  wire logic  q_full,
   input  wire logic  init_done,
   output logic       q_push,
   output item_type   q_item
);

   logic [CFG_W-1:0]  prefix_ff, prefix_in;
   logic [CFG_W-1:0]  footer_ff, footer_in;
   logic [ORD_W-1:0]  alog_c;
   logic [NEED_W-1:0] need_c;
   logic [ORD_W-1:0]  ord_c;
   logic              fit_c;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = init_done && !q_full;
   assign q_push         = req_chan.valid && req_chan.ready;

   always_comb begin
      prefix_in = prefix_ff;
      footer_in = footer_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_PREFIX: prefix_in = csr_chan.data;
            CSR_FOOTER: footer_in = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= PREFIX_RESET;
         footer_ff <= FOOTER_RESET;
      end else begin
         prefix_ff <= prefix_in;
         footer_ff <= footer_in;
      end
   end

   always_comb begin
      alog_c = (req_chan.align_log2 < ORD_W'(MIN_ALIGN_LOG2)) ?
               ORD_W'(MIN_ALIGN_LOG2) : req_chan.align_log2;
      need_c = NEED_W'(prefix_ff) + NEED_W'(req_chan.request_bytes) + NEED_W'(footer_ff)
             + ((NEED_W'(1) << alog_c) - NEED_W'(1));
      ord_c = '0;
      fit_c = 1'b0;
      for (int o = ARENA_ORDER; o >= GRAIN_ORDER; o--) begin
         if (need_c <= (NEED_W'(1) << o)) begin
            ord_c = ORD_W'(o);
            fit_c = 1'b1;
         end
      end
   end

   always_comb begin
      q_item             = '0;
      q_item.kind        = K_REJECT;
      q_item.fail_status = STATUS_OK;
      q_item.ord         = ord_c;
      q_item.size        = req_chan.request_bytes;
      q_item.alog        = alog_c;
      q_item.grain       = req_chan.free_offset[OFF_W-1:GRAIN_ORDER];
      q_item.prefix      = prefix_ff;
      if (!req_chan.opcode) begin
         if (req_chan.request_bytes == '0) begin
            q_item.fail_status = STATUS_BAD_SIZE;
         end else if (!fit_c) begin
            q_item.fail_status = STATUS_OOM;
         end else begin
            q_item.kind = K_ALLOC;
         end
      end else begin
         if (req_chan.free_offset[GRAIN_ORDER-1:0] != '0) begin
            q_item.fail_status = STATUS_BAD_FREE;
         end else begin
            q_item.kind = K_FREE;
         end
      end
   end

endmodule
`default_nettype wire

@@ rtl/bba_fifo.sv @@
`default_nettype none
module bba_fifo
   import bba_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          full,
   input  wire logic     pop,
   output item_type      pop_item,
   output logic          empty
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   item_type           slot_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign full     = (cnt_ff == CNT_W'(FIFO_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_item = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

@@ rtl/bba_back.sv @@
`default_nettype none
module bba_back
   import bba_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_empty,
   input  wire item_type q_item,
   output logic          q_pop,
   output logic          init_done,
   bba_rsp_if.source     rsp_chan
);

   typedef enum logic [15:0] {
      ST_CLEAR     = 16'h0001,
      ST_IDLE      = 16'h0002,
      ST_SEARCH    = 16'h0004,
      ST_POP_WR    = 16'h0008,
      ST_SPLIT     = 16'h0010,
      ST_ALLOC_WR  = 16'h0020,
      ST_FREE_CHK  = 16'h0040,
      ST_BUD_RD    = 16'h0080,
      ST_BUD_CHK   = 16'h0100,
      ST_UNLINK    = 16'h0200,
      ST_MERGE     = 16'h0400,
      ST_PUSH      = 16'h0800,
      ST_PUSH_LINK = 16'h1000,
      ST_DONE      = 16'h2000
   } state_type;

   state_type state_ff, state_in;

   logic [LINK_W-1:0] next_mem   [NGRAINS];
   logic [LINK_W-1:0] prev_mem   [NGRAINS];
   logic [ORD_W-1:0]  order_mem  [NGRAINS];
   logic [1:0]        status_mem [NGRAINS];
   logic [SIZE_W-1:0] ubytes_mem [NGRAINS];

   logic [LINK_W-1:0] nx_q, pv_q;
   logic [ORD_W-1:0]  or_q;
   logic [1:0]        st_q;
   logic [SIZE_W-1:0] ub_q;

   logic [GRAIN_BITS-1:0] rd_addr;
   logic                  nx_we, pv_we, or_we, st_we, ub_we, hd_we;
   logic [GRAIN_BITS-1:0] nx_wa, pv_wa, or_wa, st_wa, ub_wa;
   logic [LINK_W-1:0]     nx_wd, pv_wd, hd_wd;
   logic [ORD_W-1:0]      or_wd;
   logic [1:0]            st_wd;
   logic [SIZE_W-1:0]     ub_wd;
   logic [LIST_W-1:0]     hd_idx;

   logic [LINK_W-1:0]     heads_ff [NORDERS];
   logic [LINK_W-1:0]     head_rd;

   item_type              item_ff, item_in;
   logic [GRAIN_BITS-1:0] cur_ff, cur_in;
   logic [GRAIN_BITS-1:0] buddy_ff, buddy_in;
   logic [ORD_W-1:0]      ord_ff, ord_in;
   logic [ORD_W-1:0]      found_ff, found_in;
   logic [LINK_W-1:0]     nb_ff, nb_in;
   logic [LINK_W-1:0]     pb_ff, pb_in;
   logic [LINK_W-1:0]     hl_ff, hl_in;
   logic [GRAIN_BITS-1:0] clr_ff, clr_in;
   logic [SIZE_W-1:0]     total_ff, total_in;
   logic [SIZE_W-1:0]     peak_ff, peak_in;
   status_type            res_status_ff, res_status_in;
   logic [OFF_W-1:0]      res_boff_ff, res_boff_in;
   logic [OFF_W-1:0]      res_uoff_ff, res_uoff_in;
   logic [ORD_W-1:0]      res_ord_ff, res_ord_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [OFF_W-1:0]      rsp_boff_ff, rsp_boff_in;
   logic [OFF_W-1:0]      rsp_uoff_ff, rsp_uoff_in;
   logic [ORD_W-1:0]      rsp_ord_ff, rsp_ord_in;
   logic [SIZE_W-1:0]     rsp_total_ff, rsp_total_in;
   logic [SIZE_W-1:0]     rsp_peak_ff, rsp_peak_in;

   logic [LIST_W-1:0]     ord_idx_c, found_idx_c;
   logic                  hit_c;
   logic [LIST_W-1:0]     fidx_c;
   logic [ORD_W-1:0]      split_ord_c;
   logic [GRAIN_BITS-1:0] split_blk_c;
   logic [GRAIN_BITS-1:0] buddy_c;
   logic [SIZE_W:0]       sum_c;
   logic [SIZE_W-1:0]     new_total_c;
   logic [OFF_W+1:0]      amask_c, base_c, uoff_c;

   function automatic logic [LIST_W-1:0] hd_idx_rd();
      return (state_ff == ST_SEARCH) ? fidx_c : ord_idx_c;
   endfunction

   assign init_done = (state_ff != ST_CLEAR);

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.block_offset = rsp_boff_ff;
   assign rsp_chan.user_offset  = rsp_uoff_ff;
   assign rsp_chan.block_order  = rsp_ord_ff;
   assign rsp_chan.bytes_in_use = rsp_total_ff;
   assign rsp_chan.peak_bytes   = rsp_peak_ff;

   assign ord_idx_c   = LIST_W'(ord_ff - ORD_W'(GRAIN_ORDER));
   assign found_idx_c = LIST_W'(found_ff - ORD_W'(GRAIN_ORDER));
   assign split_ord_c = found_ff - ORD_W'(1);
   assign split_blk_c = cur_ff + (GRAIN_BITS'(1) << (split_ord_c - ORD_W'(GRAIN_ORDER)));
   assign buddy_c     = cur_ff ^ (GRAIN_BITS'(1) << (ord_ff - ORD_W'(GRAIN_ORDER)));
   assign sum_c       = (SIZE_W + 1)'(total_ff) + (SIZE_W + 1)'(item_ff.size);
   assign new_total_c = sum_c[SIZE_W] ? SIZE_MAX : sum_c[SIZE_W-1:0];
   assign amask_c     = ((OFF_W + 2)'(1) << item_ff.alog) - (OFF_W + 2)'(1);
   assign base_c      = (OFF_W + 2)'({cur_ff, GRAIN_ORDER'(0)}) + (OFF_W + 2)'(item_ff.prefix);
   assign uoff_c      = (base_c + amask_c) & ~amask_c;
   assign head_rd     = heads_ff[hd_idx_rd()];

   always_comb begin
      hit_c  = 1'b0;
      fidx_c = '0;
      for (int i = NORDERS - 1; i >= 0; i--) begin
         if (LIST_W'(i) >= ord_idx_c && heads_ff[i] != NIL) begin
            hit_c  = 1'b1;
            fidx_c = LIST_W'(i);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      cur_in        = cur_ff;
      buddy_in      = buddy_ff;
      ord_in        = ord_ff;
      found_in      = found_ff;
      nb_in         = nb_ff;
      pb_in         = pb_ff;
      hl_in         = hl_ff;
      clr_in        = clr_ff;
      total_in      = total_ff;
      peak_in       = peak_ff;
      res_status_in = res_status_ff;
      res_boff_in   = res_boff_ff;
      res_uoff_in   = res_uoff_ff;
      res_ord_in    = res_ord_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_boff_in   = rsp_boff_ff;
      rsp_uoff_in   = rsp_uoff_ff;
      rsp_ord_in    = rsp_ord_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_peak_in   = rsp_peak_ff;
      q_pop   = 1'b0;
      rd_addr = cur_ff;
      nx_we = 1'b0; nx_wa = cur_ff; nx_wd = NIL;
      pv_we = 1'b0; pv_wa = cur_ff; pv_wd = NIL;
      or_we = 1'b0; or_wa = cur_ff; or_wd = '0;
      st_we = 1'b0; st_wa = cur_ff; st_wd = GS_NONE;
      ub_we = 1'b0; ub_wa = cur_ff; ub_wd = '0;
      hd_we = 1'b0; hd_idx = ord_idx_c; hd_wd = NIL;

      case (state_ff)
         ST_CLEAR: begin
            nx_we = 1'b1; nx_wa = clr_ff;
            pv_we = 1'b1; pv_wa = clr_ff;
            or_we = 1'b1; or_wa = clr_ff;
            st_we = 1'b1; st_wa = clr_ff;
            ub_we = 1'b1; ub_wa = clr_ff;
            if (clr_ff == '0) begin
               or_wd = ORD_W'(ARENA_ORDER);
               st_wd = GS_FREE;
            end
            clr_in = clr_ff + GRAIN_BITS'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               item_in = q_item;
               cur_in  = q_item.grain;
               ord_in  = q_item.ord;
               rd_addr = q_item.grain;
               case (q_item.kind)
                  K_ALLOC: state_in = ST_SEARCH;
                  K_FREE:  state_in = ST_FREE_CHK;
                  default: begin
                     res_status_in = q_item.fail_status;
                     res_boff_in   = '0;
                     res_uoff_in   = '0;
                     res_ord_in    = '0;
                     state_in      = ST_DONE;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (hit_c) begin
               found_in = ORD_W'(fidx_c) + ORD_W'(GRAIN_ORDER);
               cur_in   = head_rd[GRAIN_BITS-1:0];
               rd_addr  = head_rd[GRAIN_BITS-1:0];
               state_in = ST_POP_WR;
            end else begin
               res_status_in = STATUS_OOM;
               res_boff_in   = '0;
               res_uoff_in   = '0;
               res_ord_in    = '0;
               state_in      = ST_DONE;
            end
         end
         ST_POP_WR: begin
            hd_we  = 1'b1;
            hd_idx = found_idx_c;
            hd_wd  = nx_q;
            if (nx_q != NIL) begin
               pv_we = 1'b1;
               pv_wa = nx_q[GRAIN_BITS-1:0];
            end
            nx_we    = 1'b1;
            state_in = (found_ff > ord_ff) ? ST_SPLIT : ST_ALLOC_WR;
         end
         ST_SPLIT: begin
            nx_we = 1'b1; nx_wa = split_blk_c;
            pv_we = 1'b1; pv_wa = split_blk_c;
            st_we = 1'b1; st_wa = split_blk_c; st_wd = GS_FREE;
            or_we = 1'b1; or_wa = split_blk_c; or_wd = split_ord_c;
            ub_we = 1'b1; ub_wa = split_blk_c;
            hd_we  = 1'b1;
            hd_idx = LIST_W'(split_ord_c - ORD_W'(GRAIN_ORDER));
            hd_wd  = LINK_W'(split_blk_c);
            found_in = split_ord_c;
            if (split_ord_c == ord_ff) begin
               state_in = ST_ALLOC_WR;
            end
         end
         ST_ALLOC_WR: begin
            st_we = 1'b1; st_wd = GS_USED;
            or_we = 1'b1; or_wd = ord_ff;
            ub_we = 1'b1; ub_wd = item_ff.size;
            total_in = new_total_c;
            if (new_total_c > peak_ff) begin
               peak_in = new_total_c;
            end
            res_status_in = STATUS_OK;
            res_boff_in   = {cur_ff, GRAIN_ORDER'(0)};
            res_uoff_in   = uoff_c[OFF_W-1:0];
            res_ord_in    = ord_ff;
            state_in      = ST_DONE;
         end
         ST_FREE_CHK: begin
            if (st_q != GS_USED) begin
               res_status_in = STATUS_BAD_FREE;
               res_boff_in   = '0;
               res_uoff_in   = '0;
               res_ord_in    = '0;
               state_in      = ST_DONE;
            end else begin
               total_in = (total_ff >= ub_q) ? total_ff - ub_q : '0;
               ub_we    = 1'b1;
               ord_in   = or_q;
               state_in = (or_q < ORD_W'(ARENA_ORDER)) ? ST_BUD_RD : ST_PUSH;
            end
         end
         ST_BUD_RD: begin
            rd_addr  = buddy_c;
            buddy_in = buddy_c;
            state_in = ST_BUD_CHK;
         end
         ST_BUD_CHK: begin
            if (st_q == GS_FREE && or_q == ord_ff) begin
               nb_in    = nx_q;
               pb_in    = pv_q;
               state_in = ST_UNLINK;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_UNLINK: begin
            if (pb_ff != NIL) begin
               nx_we = 1'b1;
               nx_wa = pb_ff[GRAIN_BITS-1:0];
               nx_wd = nb_ff;
            end else begin
               hd_we = 1'b1;
               hd_wd = nb_ff;
            end
            if (nb_ff != NIL) begin
               pv_we = 1'b1;
               pv_wa = nb_ff[GRAIN_BITS-1:0];
               pv_wd = pb_ff;
            end
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            nx_we = 1'b1; nx_wa = buddy_ff;
            pv_we = 1'b1; pv_wa = buddy_ff;
            ub_we = 1'b1; ub_wa = buddy_ff;
            st_we = 1'b1;
            or_we = 1'b1;
            if (buddy_ff < cur_ff) begin
               cur_in = buddy_ff;
            end else begin
               st_wa = buddy_ff;
               or_wa = buddy_ff;
            end
            ord_in   = ord_ff + ORD_W'(1);
            state_in = (ord_ff + ORD_W'(1) < ORD_W'(ARENA_ORDER)) ? ST_BUD_RD : ST_PUSH;
         end
         ST_PUSH: begin
            nx_we = 1'b1; nx_wd = head_rd;
            pv_we = 1'b1;
            st_we = 1'b1; st_wd = GS_FREE;
            or_we = 1'b1; or_wd = ord_ff;
            ub_we = 1'b1;
            hd_we = 1'b1; hd_wd = LINK_W'(cur_ff);
            hl_in = head_rd;
            res_status_in = STATUS_OK;
            res_boff_in   = {cur_ff, GRAIN_ORDER'(0)};
            res_uoff_in   = '0;
            res_ord_in    = ord_ff;
            state_in      = (head_rd != NIL) ? ST_PUSH_LINK : ST_DONE;
         end
         ST_PUSH_LINK: begin
            pv_we    = 1'b1;
            pv_wa    = hl_ff[GRAIN_BITS-1:0];
            pv_wd    = LINK_W'(cur_ff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_boff_in   = res_boff_ff;
               rsp_uoff_in   = res_uoff_ff;
               rsp_ord_in    = res_ord_ff;
               rsp_total_in  = total_ff;
               rsp_peak_in   = peak_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         total_ff     <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NORDERS; i++) begin
            heads_ff[i] <= (i == NORDERS - 1) ? LINK_W'(0) : NIL;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
         if (hd_we) begin
            heads_ff[hd_idx] <= hd_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      cur_ff        <= cur_in;
      buddy_ff      <= buddy_in;
      ord_ff        <= ord_in;
      found_ff      <= found_in;
      nb_ff         <= nb_in;
      pb_ff         <= pb_in;
      hl_ff         <= hl_in;
      res_status_ff <= res_status_in;
      res_boff_ff   <= res_boff_in;
      res_uoff_ff   <= res_uoff_in;
      res_ord_ff    <= res_ord_in;
      rsp_status_ff <= rsp_status_in;
      rsp_boff_ff   <= rsp_boff_in;
      rsp_uoff_ff   <= rsp_uoff_in;
      rsp_ord_ff    <= rsp_ord_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_peak_ff   <= rsp_peak_in;
   end

   always_ff @(posedge clock) begin
      if (nx_we) next_mem[nx_wa]   <= nx_wd;
      if (pv_we) prev_mem[pv_wa]   <= pv_wd;
      if (or_we) order_mem[or_wa]  <= or_wd;
      if (st_we) status_mem[st_wa] <= st_wd;
      if (ub_we) ubytes_mem[ub_wa] <= ub_wd;
      nx_q <= next_mem[rd_addr];
      pv_q <= prev_mem[rd_addr];
      or_q <= order_mem[rd_addr];
      st_q <= status_mem[rd_addr];
      ub_q <= ubytes_mem[rd_addr];
   end

endmodule
`default_nettype wire

@@ rtl/bba_checker.sv @@
`default_nettype none
module bba_checker
   import bba_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic [19:0] rsp_block_offset,
   input wire logic [19:0] rsp_user_offset,
   input wire logic [4:0]  rsp_block_order,
   input wire logic [20:0] rsp_bytes_in_use,
   input wire logic [20:0] rsp_peak_bytes
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("activity right after reset");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |->
         rsp_block_offset == '0 && rsp_user_offset == '0 && rsp_block_order == '0)
      else $error("failed transaction carries nonzero fields");

   a_ok_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |->
         rsp_block_order >= 5'(GRAIN_ORDER) && rsp_block_order <= 5'(ARENA_ORDER))
      else $error("block order out of range");

   a_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_peak_bytes >= rsp_bytes_in_use)
      else $error("peak below bytes in use");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_block_offset (rsp_chan.block_offset),
   .rsp_user_offset  (rsp_chan.user_offset),
   .rsp_block_order  (rsp_chan.block_order),
   .rsp_bytes_in_use (rsp_chan.bytes_in_use),
   .rsp_peak_bytes   (rsp_chan.peak_bytes)
);
`default_nettype wire
